// ===== rtl/fav_pkg.sv =====
`timescale 1ns / 1ps

package fav_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int MAT_DEPTH = 16;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int NUM_AXES  = 4;
    localparam int AXIS_W    = $clog2(NUM_AXES);
    localparam int NUM_PLANES = 6;
    localparam int PLANE_W   = $clog2(NUM_PLANES);

    localparam logic [AXIS_W-1:0]  AXIS_X    = AXIS_W'(0);
    localparam logic [AXIS_W-1:0]  AXIS_Y    = AXIS_W'(1);
    localparam logic [AXIS_W-1:0]  AXIS_Z    = AXIS_W'(2);
    localparam logic [AXIS_W-1:0]  AXIS_D    = AXIS_W'(3);
    localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(NUM_PLANES - 1);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef struct packed {
        logic              v;
        logic              minus;
        logic [AXIS_W-1:0] axis;
    } t_mac_step;

    typedef struct packed {
        logic plane_done;
        logic plane_neg;
    } t_mac_stat;

endpackage

// ===== rtl/frustum_aabb_visibility_test_top.sv =====
`timescale 1ns / 1ps
// A load item writes one matrix element and gives no result.
// A test item steps one shared multiply-accumulate unit through 4 terms for each of 6 planes,
// stopping at the first failing plane; the result waits in S_HOLD while an earlier one is untaken,
// and a new item is accepted once the result is registered.
// Reset (synchronous, active low) clears the matrix to zero, so every box tests visible.

module frustum_aabb_visibility_test_top import fav_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [MAT_AW-1:0]             i_element_index,
    input  logic signed [COORD_WIDTH-1:0] i_element_value,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_max_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_box_visible
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_issue, n_issue;
    logic [PLANE_W-1:0]            r_plane, n_plane;
    logic [AXIS_W-1:0]             r_axis, n_axis;
    logic [PLANE_W-1:0]            r_done_cnt, n_done_cnt;
    logic                          r_result, n_result;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_vis, n_out_vis;
    t_mac_step                     r_s1;
    logic signed [COORD_WIDTH-1:0] r_bmin [3];
    logic signed [COORD_WIDTH-1:0] r_bmax [3];

    logic                          w_accept;
    logic                          w_finish;
    logic [COORD_WIDTH-1:0]        w_w_elem;
    logic [COORD_WIDTH-1:0]        w_o_elem;
    t_mac_stat                     w_stat;

    assign o_ready       = (r_state == S_IDLE);
    assign w_accept      = i_valid && o_ready;
    assign o_valid       = r_out_valid;
    assign o_box_visible = r_out_vis;

    assign w_finish = (r_state == S_RUN) && w_stat.plane_done
                      && (w_stat.plane_neg || (r_done_cnt == PLANE_LAST));

    fav_mat_mem #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mat_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (w_accept && (i_command == CMD_LOAD)),
        .i_wr_addr   (i_element_index),
        .i_wr_data   (i_element_value),
        .i_rd_addr_a ({r_axis, 2'd3}),
        .i_rd_addr_b ({r_axis, r_plane[PLANE_W-1:1]}),
        .o_rd_data_a (w_w_elem),
        .o_rd_data_b (w_o_elem)
    );

    fav_plane_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_plane_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flush   (w_finish),
        .i_step    (r_s1),
        .i_w_elem  (w_w_elem),
        .i_o_elem  (w_o_elem),
        .i_box_min (r_bmin),
        .i_box_max (r_bmax),
        .o_stat    (w_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_plane     = r_plane;
        n_axis      = r_axis;
        n_done_cnt  = r_done_cnt;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_vis   = r_out_vis;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_command == CMD_TEST)) begin
                    n_state    = S_RUN;
                    n_issue    = 1'b1;
                    n_plane    = '0;
                    n_axis     = '0;
                    n_done_cnt = '0;
                end
            end
            S_RUN: begin
                if (r_issue) begin
                    n_axis = r_axis + 1'b1;
                    if (r_axis == AXIS_D) begin
                        if (r_plane == PLANE_LAST) begin
                            n_issue = 1'b0;
                        end else begin
                            n_plane = r_plane + 1'b1;
                        end
                    end
                end
                if (w_stat.plane_done) begin
                    if (w_finish) begin
                        n_state  = S_HOLD;
                        n_issue  = 1'b0;
                        n_result = !w_stat.plane_neg;
                    end else begin
                        n_done_cnt = r_done_cnt + 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_plane     <= '0;
            r_axis      <= '0;
            r_done_cnt  <= '0;
            r_result    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_vis   <= 1'b0;
            r_s1        <= '0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_plane     <= n_plane;
            r_axis      <= n_axis;
            r_done_cnt  <= n_done_cnt;
            r_result    <= n_result;
            r_out_valid <= n_out_valid;
            r_out_vis   <= n_out_vis;
            r_s1.v      <= r_issue && !w_finish;
            r_s1.minus  <= r_plane[0];
            r_s1.axis   <= r_axis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_command == CMD_TEST)) begin
            r_bmin[0] <= i_box_min_x;
            r_bmin[1] <= i_box_min_y;
            r_bmin[2] <= i_box_min_z;
            r_bmax[0] <= i_box_max_x;
            r_bmax[1] <= i_box_max_y;
            r_bmax[2] <= i_box_max_z;
        end
    end

    a_issue_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> (r_state == S_RUN))
        else $error("plane terms issued outside a test");

    a_done_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_done_cnt <= PLANE_LAST))
        else $error("plane count ran past the last plane");

    a_hold_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_HOLD) |-> $past(r_state == S_RUN))
        else $error("result held without a test in progress");

endmodule

// ===== rtl/fav_mat_mem.sv =====
`timescale 1ns / 1ps

module fav_mat_mem import fav_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [MAT_AW-1:0]      i_wr_addr,
    input  logic [COORD_WIDTH-1:0] i_wr_data,
    input  logic [MAT_AW-1:0]      i_rd_addr_a,
    input  logic [MAT_AW-1:0]      i_rd_addr_b,
    output logic [COORD_WIDTH-1:0] o_rd_data_a,
    output logic [COORD_WIDTH-1:0] o_rd_data_b
);

    logic [COORD_WIDTH-1:0] r_mem [MAT_DEPTH];
    logic [MAT_DEPTH-1:0]   r_valid;
    logic [COORD_WIDTH-1:0] r_rd_a;
    logic [COORD_WIDTH-1:0] r_rd_b;

    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_valid[i_rd_addr_a] ? r_mem[i_rd_addr_a] : '0;
        r_rd_b <= r_valid[i_rd_addr_b] ? r_mem[i_rd_addr_b] : '0;
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/fav_plane_mac.sv =====
`timescale 1ns / 1ps

module fav_plane_mac import fav_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_flush,
    input  t_mac_step                     i_step,
    input  logic signed [COORD_WIDTH-1:0] i_w_elem,
    input  logic signed [COORD_WIDTH-1:0] i_o_elem,
    input  logic signed [COORD_WIDTH-1:0] i_box_min [3],
    input  logic signed [COORD_WIDTH-1:0] i_box_max [3],
    output t_mac_stat                     o_stat
);

    localparam int CPW    = COORD_WIDTH + 1;
    localparam int PROD_W = CPW + COORD_WIDTH;
    localparam int D_W    = CPW + FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;

    logic signed [CPW-1:0]         w_comp;
    logic signed [COORD_WIDTH-1:0] w_min;
    logic signed [COORD_WIDTH-1:0] w_max;
    logic signed [COORD_WIDTH-1:0] w_sel;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [ACC_W-1:0]       w_dterm;
    logic signed [ACC_W-1:0]       w_sum;
    logic signed [ACC_W-1:0]       r_term;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_s2_v;
    logic                          r_s2_last;
    logic                          r_s2_first;

    always_comb begin
        if (i_step.minus) begin
            w_comp = CPW'(i_w_elem) - CPW'(i_o_elem);
        end else begin
            w_comp = CPW'(i_w_elem) + CPW'(i_o_elem);
        end
        case (i_step.axis)
            AXIS_X: begin
                w_min = i_box_min[0];
                w_max = i_box_max[0];
            end
            AXIS_Y: begin
                w_min = i_box_min[1];
                w_max = i_box_max[1];
            end
            AXIS_Z: begin
                w_min = i_box_min[2];
                w_max = i_box_max[2];
            end
            default: begin
                w_min = '0;
                w_max = '0;
            end
        endcase
        // The corner farthest along the normal takes max where the component is not negative.
        w_sel   = w_comp[CPW-1] ? w_min : w_max;
        w_prod  = PROD_W'(w_comp) * PROD_W'(w_sel);
        w_dterm = ACC_W'(w_comp) <<< FRAC_BITS;
        w_sum   = r_acc + r_term;
    end

    always_ff @(posedge i_clk) begin
        r_term <= (i_step.axis == AXIS_D) ? w_dterm : ACC_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_s2_v     <= 1'b0;
            r_s2_last  <= 1'b0;
            r_s2_first <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_s2_v     <= i_step.v;
            r_s2_last  <= (i_step.axis == AXIS_D);
            r_s2_first <= (i_step.axis == AXIS_X);
            if (r_s2_v) begin
                r_acc <= r_s2_last ? '0 : w_sum;
            end
        end
    end

    assign o_stat.plane_done = r_s2_v && r_s2_last;
    assign o_stat.plane_neg  = w_sum[ACC_W-1];

    a_acc_clear_at_plane_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && r_s2_first) |-> (r_acc == '0))
        else $error("accumulator not clear at the first term of a plane");

endmodule

// ===== tb/tb_frustum_aabb_visibility_test_top.sv =====
`timescale 1ns / 1ps

module tb_frustum_aabb_visibility_test_top import fav_pkg::*; ();

    localparam int CW = COORD_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int ITEMS_PER_PHASE = 550;

    class cull_scoreboard;
        logic signed [CW-1:0] mat [MAT_DEPTH];
        bit visible_expected [$];
        int errors;

        function new();
            foreach (mat[k]) mat[k] = '0;
            errors = 0;
        endfunction

        function bit box_in_view(logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
            logic signed [CW-1:0] lo [3];
            logic signed [CW-1:0] hi [3];
            logic signed [CW:0] wv, ov;
            logic signed [CW:0] n [NUM_AXES];
            logic signed [127:0] plane_dist, c, p;
            int row;
            lo = '{lo_x, lo_y, lo_z};
            hi = '{hi_x, hi_y, hi_z};
            for (int plane = 0; plane < NUM_PLANES; plane++) begin
                row = plane / 2;
                for (int a = 0; a < NUM_AXES; a++) begin
                    wv = (CW + 1)'(mat[a * 4 + 3]);
                    ov = (CW + 1)'(mat[a * 4 + row]);
                    n[a] = (plane % 2 == 1) ? wv - ov : wv + ov;
                end
                plane_dist = 128'(n[AXIS_D]);
                plane_dist = plane_dist <<< FB;
                for (int a = 0; a < 3; a++) begin
                    c = 128'(n[a]);
                    p = 128'((n[a] >= 0) ? hi[a] : lo[a]);
                    plane_dist = plane_dist + c * p;
                end
                if (plane_dist < 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(logic cmd, logic [MAT_AW-1:0] idx, logic signed [CW-1:0] val,
                                logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
            if (cmd == CMD_LOAD) begin
                mat[idx] = val;
            end else begin
                visible_expected.push_back(box_in_view(lo_x, lo_y, lo_z, hi_x, hi_y, hi_z));
            end
        endfunction

        function void check_visible(logic got);
            bit want;
            if (visible_expected.size() == 0) begin
                $error("box_visible: result with no item waiting, got %0b", got);
                errors++;
            end else begin
                want = visible_expected.pop_front();
                if (got !== want) begin
                    $error("box_visible: expected %0b, got %0b", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return visible_expected.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_command = CMD_LOAD;
    logic [MAT_AW-1:0]     i_element_index = '0;
    logic signed [CW-1:0]  i_element_value = '0;
    logic signed [CW-1:0]  i_box_min_x = '0;
    logic signed [CW-1:0]  i_box_min_y = '0;
    logic signed [CW-1:0]  i_box_min_z = '0;
    logic signed [CW-1:0]  i_box_max_x = '0;
    logic signed [CW-1:0]  i_box_max_y = '0;
    logic signed [CW-1:0]  i_box_max_z = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_box_visible;

    cull_scoreboard sb;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int items_sent = 0;

    frustum_aabb_visibility_test_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_box_min_x     (i_box_min_x),
        .i_box_min_y     (i_box_min_y),
        .i_box_min_z     (i_box_min_z),
        .i_box_max_x     (i_box_max_x),
        .i_box_max_y     (i_box_max_y),
        .i_box_max_z     (i_box_max_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_box_visible   (o_box_visible)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_visible(o_box_visible);
            end
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [MAT_AW-1:0] idx,
                             input logic signed [CW-1:0] val, lo_x, lo_y, lo_z,
                             hi_x, hi_y, hi_z);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_element_index <= idx;
        i_element_value <= val;
        i_box_min_x     <= lo_x;
        i_box_min_y     <= lo_y;
        i_box_min_z     <= lo_z;
        i_box_max_x     <= hi_x;
        i_box_max_y     <= hi_y;
        i_box_max_z     <= hi_z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(cmd, idx, val, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
        items_sent++;
    endtask

    task automatic send_load(input int idx, input logic signed [CW-1:0] val);
        send_item(CMD_LOAD, MAT_AW'(idx), val, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    endtask

    task automatic send_test(input logic signed [CW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
        send_item(CMD_TEST, MAT_AW'($urandom_range(MAT_DEPTH - 1)), $urandom,
                  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic int sym(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    initial begin
        logic signed [CW-1:0] vmin, vmax, one, v;
        logic signed [CW-1:0] lo [3];
        logic signed [CW-1:0] hi [3];
        int ord [MAT_DEPTH];
        int mode, j, tmp, r, col, ntests, half, ctr;
        bit zero_off, wild_box;

        sb = new();
        vmin = {1'b1, {(CW - 1){1'b0}}};
        vmax = {1'b0, {(CW - 1){1'b1}}};
        one  = CW'(1) <<< FB;

        snd_idle_pct = 31;
        rcv_idle_pct = 61;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the cleared matrix every box is visible, swapped corners too.
        send_test(vmin, vmin, vmin, vmax, vmax, vmax);
        send_test(vmax, vmax, vmax, vmin, vmin, vmin);

        // Unit-scale frustum spanning -4..4 on each axis.
        send_load(0, one);
        send_load(5, one);
        send_load(10, one);
        send_load(MAT_DEPTH - 1, one * 4);
        send_test(-one, -one, -one, one, one, one);
        send_test(one * 5, -one, -one, one * 6, one, one);
        send_test(-one * 5, -one, -one, -one * 4, one, one);
        send_test(-one * 5, -one, -one, -one * 4 - 1, one, one);
        send_test(one, one, one, -one, -one, -one);
        send_test(vmin, vmin, vmin, vmax, vmax, vmax);
        send_test(vmax, vmax, vmax, vmax, vmax, vmax);

        // Extreme matrix elements in the normal and in the plane offset.
        send_load(1, vmin);
        send_test(vmin, vmin, vmin, vmax, vmax, vmax);
        send_load(1, vmax);
        send_test(-one, -one, -one, one, one, one);
        send_load(1, '0);
        send_load(14, vmax);
        send_test(vmax, vmin, vmax, vmin, vmax, vmin);
        send_load(14, vmin);
        send_test(-one, -one, -one, one, one, one);
        send_load(14, '0);

        for (int phase = 0; phase < 3; phase++) begin
            snd_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 61 : 0;
            rcv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 31 : 0;
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                mode = $urandom_range(99);
                if (mode < 15) begin
                    for (int k = 0; k < MAT_DEPTH; k++) send_load(k, $urandom);
                end else if (mode < 30) begin
                    repeat ($urandom_range(1, 3)) send_load($urandom_range(MAT_DEPTH - 1), sym(2 << FB));
                end else begin
                    for (int k = 0; k < MAT_DEPTH; k++) ord[k] = k;
                    for (int k = MAT_DEPTH - 1; k > 0; k--) begin
                        j = $urandom_range(k);
                        tmp = ord[k];
                        ord[k] = ord[j];
                        ord[j] = tmp;
                    end
                    zero_off = 1'($urandom_range(1));
                    for (int k = 0; k < MAT_DEPTH; k++) begin
                        r = ord[k] % 4;
                        col = ord[k] / 4;
                        if (r == col && r < 3) begin
                            v = $urandom_range(1 << (FB - 1), 4 << FB);
                            if ($urandom_range(4) == 0) v = -v;
                        end else if (r < 3 && col < 3) begin
                            v = zero_off ? 0 : sym(1 << (FB - 1));
                        end else if (r < 3) begin
                            v = sym(3 << FB);
                        end else if (col < 3) begin
                            v = zero_off ? 0 : sym(1 << (FB - 3));
                        end else begin
                            v = $urandom_range(2 << FB, 12 << FB);
                        end
                        send_load(ord[k], v);
                    end
                end
                ntests = $urandom_range(10, 40);
                for (int t = 0; t < ntests; t++) begin
                    wild_box = (mode < 15) || ($urandom_range(9) == 0);
                    for (int a = 0; a < 3; a++) begin
                        if (wild_box) begin
                            lo[a] = $urandom;
                            hi[a] = $urandom;
                        end else begin
                            ctr = sym(10 << FB);
                            half = $urandom_range(0, 3 << FB);
                            lo[a] = ctr - half;
                            hi[a] = ctr + half;
                            if ($urandom_range(19) == 0) begin
                                lo[a] = ctr + half;
                                hi[a] = ctr - half;
                            end
                        end
                    end
                    send_test(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
                end
            end
            // Hold the sender off until every outstanding result is back.
            drain_results();
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("box_visible: %0d expected results never arrived", sb.pending());
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== frustum_aabb_visibility_test_top.f =====
rtl/fav_pkg.sv
rtl/fav_mat_mem.sv
rtl/fav_plane_mac.sv
rtl/frustum_aabb_visibility_test_top.sv
tb/tb_frustum_aabb_visibility_test_top.sv
